@@ src/des_ks_pkg.sv @@
// shared types, constants and permutation functions for the des key schedule
package des_ks_pkg;

  localparam int unsigned KEY_W    = 56;
  localparam int unsigned HALF_W   = 28;
  localparam int unsigned SUBKEY_W = 48;
  localparam int unsigned ROUND_W  = 4;

  localparam logic [ROUND_W-1:0] ROUND_LAST = 4'd15;

  // bit r set: round r rotates both halves by two places, else by one
  localparam logic [15:0] ROT_TWO = 16'b0111_1110_1111_1100;

  // pc-2 entries, numbered from 1 at the msb of c||d
  localparam logic [5:0] PC2 [SUBKEY_W] = '{
    6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,  6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
    6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,  6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
    6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55, 6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
    6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53, 6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
  };

  // head of the key queue as seen by the round engine
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
  } head_t;

  // round engine status
  typedef struct packed {
    logic               active;
    logic [ROUND_W-1:0] round;
  } eng_stat_t;

  function automatic logic [HALF_W-1:0] rotl28(input logic [HALF_W-1:0] v,
                                                input logic two);
    logic [HALF_W-1:0] r;
    if (two) begin
      r = {v[HALF_W-3:0], v[HALF_W-1:HALF_W-2]};
    end else begin
      r = {v[HALF_W-2:0], v[HALF_W-1]};
    end
    return r;
  endfunction

  function automatic logic [SUBKEY_W-1:0] pc2(input logic [KEY_W-1:0] cd);
    logic [SUBKEY_W-1:0] res;
    logic [5:0]          src;
    res = '0;
    for (int k = 0; k < SUBKEY_W; k++) begin
      src = 6'(KEY_W - 32'(PC2[k]));
      res[SUBKEY_W-1-k] = cd[src];
    end
    return res;
  endfunction

endpackage

@@ src/des_ks_front.sv @@
// two-entry key queue in front of the round engine
module des_ks_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            key_valid,
  output logic                            key_stall,
  input  logic [des_ks_pkg::KEY_W-1:0]    key_pc1,
  input  logic                            pop,
  output des_ks_pkg::head_t               head
);

  logic [des_ks_pkg::KEY_W-1:0] entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign key_stall = (count == 2'd2);
  assign push      = key_valid && !key_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= key_pc1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  assign head.valid = (count != 2'd0);
  assign head.key   = entry[rd_ptr];

endmodule

@@ src/des_ks_engine.sv @@
// round engine: rotates the halves and registers one subkey per cycle while the output is not stalled
module des_ks_engine (
  input  logic                                clk,
  input  logic                                rst,
  input  des_ks_pkg::head_t                   head,
  output logic                                pop,
  output des_ks_pkg::eng_stat_t               stat,
  output logic                                sub_valid,
  input  logic                                sub_stall,
  output logic [des_ks_pkg::SUBKEY_W-1:0]     subkey,
  output logic [des_ks_pkg::ROUND_W-1:0]      round_index,
  output logic                                last_round
);

  logic                              active;
  logic [des_ks_pkg::ROUND_W-1:0]    round;
  logic [des_ks_pkg::HALF_W-1:0]     c_half;
  logic [des_ks_pkg::HALF_W-1:0]     d_half;

  logic                              can_emit;
  logic                              emit;
  logic                              two;
  logic [des_ks_pkg::ROUND_W-1:0]    rnd;
  logic [des_ks_pkg::HALF_W-1:0]     c_src;
  logic [des_ks_pkg::HALF_W-1:0]     d_src;
  logic [des_ks_pkg::HALF_W-1:0]     c_next;
  logic [des_ks_pkg::HALF_W-1:0]     d_next;

  assign can_emit = !sub_valid || !sub_stall;
  assign emit     = can_emit && (active || head.valid);
  // a new key starts its first round in the cycle it leaves the queue
  assign pop      = can_emit && !active && head.valid;

  always_comb begin
    if (active) begin
      c_src = c_half;
      d_src = d_half;
      rnd   = round;
    end else begin
      c_src = head.key[des_ks_pkg::KEY_W-1:des_ks_pkg::HALF_W];
      d_src = head.key[des_ks_pkg::HALF_W-1:0];
      rnd   = '0;
    end
    two    = des_ks_pkg::ROT_TWO[rnd];
    c_next = des_ks_pkg::rotl28(c_src, two);
    d_next = des_ks_pkg::rotl28(d_src, two);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      round     <= '0;
      c_half    <= '0;
      d_half    <= '0;
      sub_valid <= 1'b0;
    end else begin
      if (emit) begin
        c_half    <= c_next;
        d_half    <= d_next;
        round     <= rnd + 4'd1;
        active    <= (rnd != des_ks_pkg::ROUND_LAST);
        sub_valid <= 1'b1;
      end else if (!sub_stall) begin
        sub_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      subkey      <= des_ks_pkg::pc2({c_next, d_next});
      round_index <= rnd;
      last_round  <= (rnd == des_ks_pkg::ROUND_LAST);
    end
  end

  assign stat.active = active;
  assign stat.round  = round;

endmodule

@@ src/des_key_schedule.sv @@
// a key accepted into an empty block is written into the queue, then the engine registers its round 0 subkey
// throughput: one subkey per cycle while the output is not stalled, set by the round engine
// a two-key queue sits in front of the engine; the subkey output is a register
// sync reset clears the queue, the engine state and the output valid
// top level of the des key schedule
module des_key_schedule (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                key_valid,
  output logic                                key_stall,
  input  logic [des_ks_pkg::KEY_W-1:0]        key_pc1,
  output logic                                sub_valid,
  input  logic                                sub_stall,
  output logic [des_ks_pkg::SUBKEY_W-1:0]     subkey,
  output logic [des_ks_pkg::ROUND_W-1:0]      round_index,
  output logic                                last_round
);

  des_ks_pkg::head_t     head;
  des_ks_pkg::eng_stat_t stat;
  logic                  pop;

  des_ks_front u_front (
    .clk       (clk),
    .rst       (rst),
    .key_valid (key_valid),
    .key_stall (key_stall),
    .key_pc1   (key_pc1),
    .pop       (pop),
    .head      (head)
  );

  des_ks_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .pop         (pop),
    .stat        (stat),
    .sub_valid   (sub_valid),
    .sub_stall   (sub_stall),
    .subkey      (subkey),
    .round_index (round_index),
    .last_round  (last_round)
  );

`ifndef NO_ASSERTIONS
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    sub_valid |-> (last_round == (round_index == des_ks_pkg::ROUND_LAST)))
    else $error("last_round does not match round_index");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("engine took a key from an empty queue");

  a_first_round: assert property (@(posedge clk) disable iff (rst)
    (key_valid && !key_stall && !head.valid && !stat.active && !sub_valid)
      |-> ##2 (sub_valid && round_index == '0))
    else $error("key into idle block did not start round 0 on time");

  a_round_follow: assert property (@(posedge clk) disable iff (rst)
    (sub_valid && !sub_stall && !last_round) |-> stat.active)
    else $error("engine went idle before the last round");
`endif

endmodule
